// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of the key table search block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define SKTS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle leads to a result in the next cycle.
`define SKTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/skts_pkg.sv =====
// Package with the constants and codes of the sorted key table search block.
package skts_pkg;

	localparam int unsigned KEY_LEN_DEF   = 12;
	localparam int unsigned ENTRY_CAP_DEF = 1024;

	localparam int unsigned CFG_W    = 11;
	localparam int unsigned S_DATA_W = 24;
	localparam int unsigned S_USER_W = 2;
	localparam int unsigned M_DATA_W = 24;
	localparam int unsigned POS_W    = 11;

	localparam logic [CFG_W-1:0] ENTRIES_RST = 11'd1024;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;
	localparam logic MODE_EXACT = 1'b0;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [1:0] STATUS_SHORT     = 2'd2;

	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CASE_OFS = 8'h20;

	localparam int unsigned MIN_EXACT_LETTERS = 2;

endpackage

// ===== sv/sorted_key_table_search.sv =====
// Top level of the sorted key table search block.
// Table writes and query characters that are not last are taken whenever the block is idle.
// A binary search pass probes with one setup step plus a read and a compare step per key byte
// compared, ends with a setup step unless an exact hit ends it; prefix mode runs two passes.
// The result word is loaded once the previous word has left; no word is taken meanwhile.
// Reset clears control and query and sets the entry count to 1024, not the key RAM.
module sorted_key_table_search #(
	parameter int unsigned KEY_LEN        = skts_pkg::KEY_LEN_DEF,
	parameter int unsigned ENTRY_CAPACITY = skts_pkg::ENTRY_CAP_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [skts_pkg::CFG_W-1:0]    cfg_wdata,  // entries_in_use
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [skts_pkg::S_DATA_W-1:0] s_tdata,    // entry_index, byte_position, byte_value
	input  logic [skts_pkg::S_USER_W-1:0] s_tuser,    // command, search_mode
	input  logic                          s_tlast,    // last_char
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [skts_pkg::M_DATA_W-1:0] m_tdata     // status, position, match_count
);

	import skts_pkg::*;

	localparam int unsigned CW = $clog2(ENTRY_CAPACITY + 1);
	localparam int unsigned AW = $clog2(ENTRY_CAPACITY * KEY_LEN);
	localparam int unsigned BW = $clog2(KEY_LEN);
	localparam int unsigned LW = $clog2(KEY_LEN + 1);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SETUP  = 5'b00010,
		ST_READ   = 5'b00100,
		ST_CMP    = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t            state_q;
	logic [CFG_W-1:0]  entries_q;
	logic [7:0]        query_q [KEY_LEN];
	logic [LW-1:0]     letter_q;
	logic              exact_q;
	logic              pass_q;
	logic [CW-1:0]     lo_q;
	logic [CW-1:0]     hi_q;
	logic [CW-1:0]     mid_q;
	logic [CW-1:0]     first_q;
	logic [AW-1:0]     addr_q;
	logic [BW-1:0]     byte_q;
	logic [1:0]        res_status_q;
	logic [POS_W-1:0]  res_pos_q;
	logic [POS_W-1:0]  res_cnt_q;
	logic              m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	logic          cmd;
	logic          mode;
	logic [9:0]    entry;
	logic [3:0]    bpos;
	logic [7:0]    bval;
	logic [7:0]    ch_low;
	logic          keep;
	logic [LW-1:0] letter_nx;
	logic          acc;
	logic          start;
	logic          short_key;
	logic [CW-1:0] live;
	logic [CW-1:0] mid_nx;
	logic          range_open;
	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    rdata;
	logic [7:0]    qbyte;
	logic          eq;
	logic          lt;
	logic          last_byte;
	logic          cmp_next;
	logic          exact_found;
	logic          move_right;
	logic          out_free;
	logic          finish_go;

	assign cmd   = s_tuser[0];
	assign mode  = s_tuser[1];
	assign entry = s_tdata[9:0];
	assign bpos  = s_tdata[13:10];
	assign bval  = s_tdata[21:14];

	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		ch_low = ((bval >= CH_UP_A) && (bval <= CH_UP_Z)) ? bval + CASE_OFS : bval;
		keep = (ch_low >= CH_LO_A) && (ch_low <= CH_LO_Z) && (32'(letter_q) < KEY_LEN);
		letter_nx = keep ? letter_q + LW'(1) : letter_q;
		start = acc && (cmd == CMD_QUERY) && s_tlast;
		short_key = (mode == MODE_EXACT) ? (32'(letter_nx) < MIN_EXACT_LETTERS)
			: (letter_nx == '0);
		live = (32'(entries_q) > ENTRY_CAPACITY) ? CW'(ENTRY_CAPACITY) : CW'(entries_q);
		mid_nx = lo_q + ((hi_q - lo_q) >> 1);
		range_open = lo_q < hi_q;
		we = acc && (cmd == CMD_WRITE) && (32'(entry) < ENTRY_CAPACITY)
			&& (32'(bpos) < KEY_LEN);
		waddr = AW'(32'(entry) * KEY_LEN + 32'(bpos));
		qbyte = query_q[byte_q];
		eq = (rdata == qbyte);
		lt = (rdata < qbyte);
		last_byte = (32'(byte_q) + 32'd1) == (exact_q ? KEY_LEN : 32'(letter_q));
		cmp_next = (state_q == ST_CMP) && eq && !last_byte;
		exact_found = (state_q == ST_CMP) && eq && last_byte && exact_q;
		move_right = lt || (eq && !exact_q && pass_q);
		finish_go = (state_q == ST_FINISH) && out_free;
	end

	skts_ram #(
		.WIDTH(8),
		.DEPTH(ENTRY_CAPACITY * KEY_LEN)
	) u_key_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (bval),
		.re    (state_q == ST_READ),
		.raddr (addr_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			entries_q  <= ENTRIES_RST;
			letter_q   <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < KEY_LEN; i++) begin
				query_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				entries_q <= cfg_wdata;
			end
			if (finish_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (acc && (cmd == CMD_QUERY)) begin
				if (keep) begin
					query_q[letter_q[BW-1:0]] <= ch_low;
				end
				letter_q <= letter_nx;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= short_key ? ST_FINISH : ST_SETUP;
					end
				end
				ST_SETUP: begin
					if (range_open) begin
						state_q <= ST_READ;
					end else if (exact_q || pass_q) begin
						state_q <= ST_FINISH;
					end
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (cmp_next) begin
						state_q <= ST_READ;
					end else if (exact_found) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_SETUP;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q  <= ST_IDLE;
						letter_q <= '0;
						for (int i = 0; i < KEY_LEN; i++) begin
							query_q[i] <= '0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			exact_q   <= (mode == MODE_EXACT);
			pass_q    <= 1'b0;
			lo_q      <= '0;
			hi_q      <= live;
			res_pos_q <= '0;
			res_cnt_q <= '0;
			if (mode == MODE_EXACT) begin
				res_status_q <= short_key ? STATUS_SHORT : STATUS_NOT_FOUND;
			end else begin
				res_status_q <= STATUS_OK;
			end
		end
		if (state_q == ST_SETUP) begin
			if (range_open) begin
				mid_q  <= mid_nx;
				addr_q <= AW'(32'(mid_nx) * KEY_LEN);
				byte_q <= '0;
			end else if (!exact_q && !pass_q) begin
				first_q <= lo_q;
				lo_q    <= '0;
				hi_q    <= live;
				pass_q  <= 1'b1;
			end else if (!exact_q) begin
				res_pos_q <= POS_W'(first_q);
				res_cnt_q <= POS_W'(lo_q - first_q);
			end
		end
		if (state_q == ST_CMP) begin
			if (cmp_next) begin
				byte_q <= byte_q + BW'(1);
				addr_q <= addr_q + AW'(1);
			end else if (exact_found) begin
				res_status_q <= STATUS_OK;
				res_pos_q    <= POS_W'(mid_q);
			end else if (move_right) begin
				lo_q <= mid_q + CW'(1);
			end else begin
				hi_q <= mid_q;
			end
		end
		if (finish_go) begin
			m_tdata_q <= {res_cnt_q, res_pos_q, res_status_q};
		end
	end

endmodule

// ===== sv/skts_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module skts_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/skts_checker.sv =====
// Port-level checker for the sorted key table search block, bound to the top level.
`include "assert_macros.svh"

module skts_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [skts_pkg::S_USER_W-1:0] s_tuser,
	input logic                          s_tlast,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [skts_pkg::M_DATA_W-1:0] m_tdata
);

	import skts_pkg::*;

	logic status_known;
	logic fields_zero;

	assign status_known = (m_tdata[1:0] == STATUS_OK) || (m_tdata[1:0] == STATUS_NOT_FOUND)
		|| (m_tdata[1:0] == STATUS_SHORT);
	assign fields_zero = (m_tdata[M_DATA_W-1:2] == '0);

	`SKTS_ASSERT(a_status_code, !m_tvalid || status_known, "Undefined status code.")

	`SKTS_ASSERT(a_fail_zero, !m_tvalid || (m_tdata[1:0] == STATUS_OK) || fields_zero, "Failed search with nonzero fields.")

	`SKTS_ASSERT_NEXT(a_search_busy, s_tvalid && s_tready && s_tlast && (s_tuser[0] == CMD_QUERY), !s_tready, "Block must be busy after the last query word.")

	`SKTS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "Stalled result word changed.")

endmodule

bind sorted_key_table_search skts_checker u_skts_checker (.*);

// ===== tb/sorted_key_table_search_tb.sv =====
// Testbench for the sorted key table search: loads a sorted key table, runs directed and random queries, checks every result against its expected value.
module sorted_key_table_search_tb;
	import skts_pkg::*;

	localparam logic MODE_PREFIX = 1'b1;
	localparam int unsigned TABLE_ENTRIES = 48;
	localparam int unsigned SEGMENTS = 6;
	localparam int unsigned SEGMENT_WORDS = 40;
	localparam int unsigned CFG_SETTLE = 20;
	localparam int unsigned DRAIN_CYCLES = 600;
	localparam int unsigned STALL_LIMIT = 20000;
	localparam int unsigned ROW_COUNT = 16;

	typedef struct packed {
		logic [POS_W-1:0] match_count;
		logic [POS_W-1:0] position;
		logic [1:0]       status;
	} search_result_t;

	typedef struct packed {
		logic             set_cfg;
		logic [CFG_W-1:0] cfg;
		logic             cmd;
		logic [9:0]       entry;
		logic [3:0]       bpos;
		logic [7:0]       bval;
		logic [8*13-1:0]  text;
		logic             mode;
		logic             typed;
		logic [1:0]       w_status;
		logic [POS_W-1:0] w_pos;
		logic [POS_W-1:0] w_count;
	} directed_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [S_USER_W-1:0] s_tuser = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	logic [7:0] key_mem [ENTRY_CAP_DEF][KEY_LEN_DEF];
	logic [7:0] query_buf [KEY_LEN_DEF];
	int unsigned query_len = 0;
	logic [CFG_W-1:0] entries_cfg = ENTRIES_RST;
	logic [8*KEY_LEN_DEF-1:0] sorted_keys [TABLE_ENTRIES];
	search_result_t pending_results [$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned err_count = 0;
	int unsigned words_counted = 0;
	int unsigned table_words = 0;
	int unsigned query_words = 0;
	int unsigned results_seen = 0;
	int unsigned settings_used = 0;
	int unsigned stall_cycles = 0;

	directed_row_t directed_rows [ROW_COUNT] = '{
		'{1'b1, CFG_W'(TABLE_ENTRIES), CMD_QUERY, 10'd0, 4'd0, 8'd0, "aa", MODE_EXACT, 1'b1,
			STATUS_OK, 11'd0, 11'd0},
		'{1'b0, 11'd0, CMD_QUERY, 10'd0, 4'd0, 8'd0, "ZZZZZZZZZZZZz", MODE_EXACT, 1'b1,
			STATUS_OK, POS_W'(TABLE_ENTRIES - 1), 11'd0},
		'{1'b0, 11'd0, CMD_QUERY, 10'd0, 4'd0, 8'd0, "a", MODE_PREFIX, 1'b1,
			STATUS_OK, 11'd0, 11'd1},
		'{1'b0, 11'd0, CMD_QUERY, 10'd0, 4'd0, 8'd0, "3#", MODE_PREFIX, 1'b1,
			STATUS_OK, 11'd0, 11'd0},
		'{1'b0, 11'd0, CMD_QUERY, 10'd0, 4'd0, 8'd0, "y", MODE_PREFIX, 1'b1,
			STATUS_OK, POS_W'(TABLE_ENTRIES - 1), 11'd0},
		'{1'b0, 11'd0, CMD_QUERY, 10'd0, 4'd0, 8'd0, "ab", MODE_EXACT, 1'b1,
			STATUS_NOT_FOUND, 11'd0, 11'd0},
		'{1'b0, 11'd0, CMD_QUERY, 10'd0, 4'd0, 8'd0, "b.c", MODE_PREFIX, 1'b0,
			STATUS_OK, 11'd0, 11'd0},
		'{1'b0, 11'd0, CMD_WRITE, 10'd1022, 4'd12, 8'h00, 104'd0, MODE_EXACT, 1'b0,
			STATUS_OK, 11'd0, 11'd0},
		'{1'b0, 11'd0, CMD_WRITE, 10'd1022, 4'd15, 8'h00, 104'd0, MODE_EXACT, 1'b0,
			STATUS_OK, 11'd0, 11'd0},
		'{1'b1, CFG_W'(TABLE_ENTRIES), CMD_QUERY, 10'd0, 4'd0, 8'd0, "z", MODE_PREFIX, 1'b1,
			STATUS_OK, POS_W'(TABLE_ENTRIES - 1), 11'd1},
		'{1'b1, CFG_W'(TABLE_ENTRIES - 1), CMD_QUERY, 10'd0, 4'd0, 8'd0, "z", MODE_PREFIX,
			1'b1, STATUS_OK, POS_W'(TABLE_ENTRIES - 1), 11'd0},
		'{1'b1, 11'd1, CMD_QUERY, 10'd0, 4'd0, 8'd0, "aa", MODE_EXACT, 1'b1,
			STATUS_OK, 11'd0, 11'd0},
		'{1'b0, 11'd0, CMD_QUERY, 10'd0, 4'd0, 8'd0, "b", MODE_PREFIX, 1'b1,
			STATUS_OK, 11'd1, 11'd0},
		'{1'b1, 11'd0, CMD_QUERY, 10'd0, 4'd0, 8'd0, "aa", MODE_EXACT, 1'b1,
			STATUS_NOT_FOUND, 11'd0, 11'd0},
		'{1'b0, 11'd0, CMD_QUERY, 10'd0, 4'd0, 8'd0, "a", MODE_EXACT, 1'b1,
			STATUS_SHORT, 11'd0, 11'd0},
		'{1'b0, 11'd0, CMD_WRITE, 10'd0, 4'd0, CH_LO_A, 104'd0, MODE_EXACT, 1'b0,
			STATUS_OK, 11'd0, 11'd0}
	};

	sorted_key_table_search dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void note_failure(string what);
		err_count++;
		if (err_count <= 10) begin
			$display("Mismatch %0d: %s", err_count, what);
		end
	endfunction

	function automatic int unsigned live_entries();
		return (entries_cfg > ENTRY_CAP_DEF) ? ENTRY_CAP_DEF : entries_cfg;
	endfunction

	function automatic int key_order(int unsigned idx, int unsigned n);
		int unsigned i;
		for (i = 0; i < n && i < KEY_LEN_DEF; i++) begin
			if (key_mem[idx][i] != query_buf[i]) begin
				return (key_mem[idx][i] < query_buf[i]) ? -1 : 1;
			end
		end
		return 0;
	endfunction

	function automatic int unsigned key_bound(bit upper);
		int unsigned lo, hi, mid;
		int c;
		lo = 0;
		hi = live_entries();
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			c = key_order(mid, query_len);
			if (upper ? c <= 0 : c < 0) begin
				lo = mid + 1;
			end else begin
				hi = mid;
			end
		end
		return lo;
	endfunction

	function automatic search_result_t search_outcome(logic mode);
		search_result_t r;
		int unsigned lo, hi, mid;
		int c;
		bit hit;
		r = '0;
		if (mode == MODE_EXACT) begin
			if (query_len < MIN_EXACT_LETTERS) begin
				r.status = STATUS_SHORT;
			end else begin
				r.status = STATUS_NOT_FOUND;
				lo = 0;
				hi = live_entries();
				hit = 1'b0;
				while (lo < hi && !hit) begin
					mid = lo + (hi - lo) / 2;
					c = key_order(mid, KEY_LEN_DEF);
					if (c == 0) begin
						hit = 1'b1;
						r.status = STATUS_OK;
						r.position = POS_W'(mid);
					end else if (c < 0) begin
						lo = mid + 1;
					end else begin
						hi = mid;
					end
				end
			end
		end else if (query_len > 0) begin
			lo = key_bound(1'b0);
			hi = key_bound(1'b1);
			r.position = POS_W'(lo);
			r.match_count = POS_W'((hi > lo) ? hi - lo : 0);
		end
		return r;
	endfunction

	function automatic void track_word(logic cmd, logic [9:0] entry, logic [3:0] bpos,
			logic [7:0] bval, logic last, logic mode);
		logic [7:0] ch;
		int unsigned i;
		if (cmd == CMD_WRITE) begin
			table_words++;
			if (bpos < KEY_LEN_DEF) begin
				key_mem[entry][bpos] = bval;
				words_counted++;
			end
			return;
		end
		query_words++;
		words_counted++;
		ch = bval;
		if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
			ch = ch + CASE_OFS;
		end
		if (ch >= CH_LO_A && ch <= CH_LO_Z && query_len < KEY_LEN_DEF) begin
			query_buf[query_len] = ch;
			query_len++;
		end
		if (last) begin
			pending_results.push_back(search_outcome(mode));
			for (i = 0; i < KEY_LEN_DEF; i++) begin
				query_buf[i] = 8'h00;
			end
			query_len = 0;
		end
	endfunction

	task automatic send_word(input logic cmd, input logic [9:0] entry, input logic [3:0] bpos,
			input logic [7:0] bval, input logic last, input logic mode);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, bval, bpos, entry};
		s_tuser <= {mode, cmd};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		track_word(cmd, entry, bpos, bval, last, mode);
	endtask

	task automatic set_entries(input logic [CFG_W-1:0] value);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (CFG_SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		entries_cfg = value;
		settings_used++;
	endtask

	function automatic logic [7:0] noise_char();
		logic [7:0] c;
		do c = 8'($urandom_range(255));
		while ((c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z));
		return c;
	endfunction

	task automatic load_key_table();
		logic [8*KEY_LEN_DEF-1:0] k;
		int i, j, len;
		for (i = 1; i < TABLE_ENTRIES - 1; i++) begin
			k = '0;
			if ($urandom_range(99) < 5) begin
				len = 1;
			end else if ($urandom_range(99) < 5) begin
				len = KEY_LEN_DEF;
			end else begin
				len = $urandom_range(2, 8);
			end
			for (j = 0; j < len; j++) begin
				k[8*KEY_LEN_DEF-1-8*j -: 8] = 8'(CH_LO_A + 1 + $urandom_range(3));
			end
			sorted_keys[i] = k;
		end
		for (i = 2; i < TABLE_ENTRIES - 1; i++) begin
			k = sorted_keys[i];
			j = i;
			while (j > 1 && sorted_keys[j-1] > k) begin
				sorted_keys[j] = sorted_keys[j-1];
				j--;
			end
			sorted_keys[j] = k;
		end
		sorted_keys[0] = {CH_LO_A, CH_LO_A, 80'd0};
		sorted_keys[TABLE_ENTRIES-1] = {KEY_LEN_DEF{CH_LO_Z}};
		for (i = 0; i < TABLE_ENTRIES; i++) begin
			for (j = 0; j < KEY_LEN_DEF; j++) begin
				send_word(CMD_WRITE, 10'(i), 4'(j), sorted_keys[i][8*KEY_LEN_DEF-1-8*j -: 8],
					1'b0, MODE_EXACT);
			end
		end
	endtask

	task automatic run_random_sequence();
		int unsigned pick, e, p, klen, qlen, n, i;
		logic mode, trail;
		logic [7:0] c;
		logic [7:0] letters [$];
		pick = $urandom_range(99);
		if (pick < 10) begin
			send_word(CMD_WRITE, 10'($urandom_range(1023)), 4'($urandom_range(KEY_LEN_DEF, 15)),
				8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
		end else if (pick < 15) begin
			e = $urandom_range(TABLE_ENTRIES - 1);
			p = $urandom_range(KEY_LEN_DEF - 1);
			send_word(CMD_WRITE, 10'(e), 4'(p), key_mem[e][p], 1'($urandom_range(1)),
				1'($urandom_range(1)));
		end else if (pick < 27) begin
			n = $urandom_range(1, 16);
			for (i = 0; i < n; i++) begin
				send_word(CMD_QUERY, 10'($urandom_range(1023)), 4'($urandom_range(15)),
					8'($urandom_range(255)), i == n - 1, 1'($urandom_range(1)));
			end
		end else begin
			e = $urandom_range(TABLE_ENTRIES - 1);
			klen = 0;
			while (klen < KEY_LEN_DEF && key_mem[e][klen] != 8'h00) klen++;
			if (klen == 0) begin
				klen = 1;
			end
			mode = 1'($urandom_range(1));
			qlen = (mode == MODE_EXACT) ? klen : $urandom_range(1, klen);
			for (i = 0; i < qlen; i++) begin
				letters.push_back(key_mem[e][i]);
			end
			if ($urandom_range(99) < 20) begin
				letters[$urandom_range(qlen - 1)] = 8'(CH_LO_A + $urandom_range(25));
			end
			if ($urandom_range(99) < 8) begin
				n = $urandom_range(1, 6);
				for (i = 0; i < n; i++) begin
					letters.push_back(8'(CH_LO_A + $urandom_range(25)));
				end
			end
			trail = ($urandom_range(99) < 10);
			for (i = 0; i < letters.size(); i++) begin
				if ($urandom_range(99) < 10) begin
					send_word(CMD_QUERY, 10'($urandom_range(1023)), 4'($urandom_range(15)),
						noise_char(), 1'b0, mode);
				end
				c = letters[i];
				if ($urandom_range(1)) begin
					c = c - CASE_OFS;
				end
				send_word(CMD_QUERY, 10'($urandom_range(1023)), 4'($urandom_range(15)), c,
					i == letters.size() - 1 && !trail, mode);
			end
			if (trail) begin
				send_word(CMD_QUERY, 10'($urandom_range(1023)), 4'($urandom_range(15)),
					noise_char(), 1'b1, mode);
			end
		end
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin : result_check
		search_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			results_seen++;
			if (pending_results.size() == 0) begin
				note_failure($sformatf("unexpected result status %0d position %0d count %0d",
					got.status, got.position, got.match_count));
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.position !== want.position ||
						got.match_count !== want.match_count) begin
					note_failure($sformatf({"result %0d: expected status %0d position %0d ",
						"count %0d, got status %0d position %0d count %0d"}, results_seen,
						want.status, want.position, want.match_count,
						got.status, got.position, got.match_count));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("No word moved for %0d cycles with %0d results outstanding.",
					stall_cycles, pending_results.size());
				$display("FAIL sorted_key_table_search");
				$finish;
			end
		end
	end

	initial begin : stimulus
		directed_row_t row;
		logic [7:0] c;
		int r, i, seg;
		int unsigned seg_start;
		for (i = 0; i < KEY_LEN_DEF; i++) begin
			query_buf[i] = 8'h00;
		end
		send_idle_pct = 14;
		recv_idle_pct = 78;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		load_key_table();

		for (r = 0; r < ROW_COUNT; r++) begin
			row = directed_rows[r];
			if (row.set_cfg) begin
				set_entries(row.cfg);
			end
			if (row.cmd == CMD_WRITE) begin
				send_word(CMD_WRITE, row.entry, row.bpos, row.bval, 1'b0, MODE_EXACT);
			end else begin
				for (i = 12; i >= 0; i--) begin
					c = row.text[8*i +: 8];
					if (c != 8'h00) begin
						send_word(CMD_QUERY, 10'($urandom_range(1023)), 4'($urandom_range(15)),
							c, i == 0, row.mode);
					end
				end
				if (row.typed) begin
					pending_results[pending_results.size()-1] =
						'{row.w_count, row.w_pos, row.w_status};
				end
			end
		end

		for (seg = 0; seg < SEGMENTS; seg++) begin
			send_idle_pct = (seg < 2) ? 14 : (seg < 4) ? 78 : 0;
			recv_idle_pct = (seg < 2) ? 78 : (seg < 4) ? 14 : 0;
			unique case (seg)
				0: set_entries(CFG_W'(TABLE_ENTRIES));
				1: set_entries(CFG_W'(TABLE_ENTRIES));
				3: set_entries(11'd2);
				5: set_entries(11'd1);
				default: set_entries(CFG_W'($urandom_range(3, TABLE_ENTRIES - 2)));
			endcase
			seg_start = words_counted;
			while (words_counted - seg_start < SEGMENT_WORDS) run_random_sequence();
		end

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d table writes and %0d query characters under %0d entry counts.",
			table_words, query_words, settings_used);
		$display("Checked %0d search results, %0d mismatches.", results_seen, err_count);
		if (err_count == 0) begin
			$display("PASS sorted_key_table_search");
		end else begin
			$display("FAIL sorted_key_table_search");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/skts_pkg.sv
sv/skts_ram.sv
sv/sorted_key_table_search.sv
sv/skts_checker.sv
tb/sorted_key_table_search_tb.sv
